>>> hdl/wfa_pkg.sv
// Shared types and constants for the wide fixed-point ALU.
// Used by wfa_addsub, wfa_mul and wide_fixed_point_alu; no dependencies.
`default_nettype none
package wfa_pkg;

    localparam int INT_W   = 32;
    localparam int FRAC_W  = 96;
    localparam int MAG_W   = INT_W + FRAC_W;
    localparam int WORD_W  = 32;
    localparam int WORDS   = MAG_W / WORD_W;
    localparam int DEPTH   = 5;
    localparam int IN_W    = 264;
    localparam int OUT_W   = 136;

    // operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        logic sign;
        mag_t mag;
        logic ovf;
    } result_t;

endpackage
`default_nettype wire

>>> hdl/wfa_addsub.sv
// Sign-magnitude add/subtract path: compare/swap stage, add stage, then
// delay stages to match the multiplier latency. Depends on wfa_pkg.
`default_nettype none
module wfa_addsub
    import wfa_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    en,
    input  wire logic [1:0] op,
    input  wire logic    a_sign,
    input  wire mag_t    a_mag,
    input  wire logic    b_sign,
    input  wire mag_t    b_mag,
    output result_t      res
);

    logic    same_reg, same_next;
    logic    sign_reg, sign_next;
    mag_t    x_reg, x_next;
    mag_t    y_reg, y_next;
    result_t dly_reg [DEPTH-1];
    result_t sum_next;
    logic    sb_eff;
    logic [MAG_W:0] wide;

    // stage 1: effective signs, order magnitudes for subtraction
    always_comb
    begin
        sb_eff    = b_sign ^ (op == OP_SUB);
        same_next = (a_sign == sb_eff);
        sign_next = a_sign;
        x_next    = a_mag;
        y_next    = b_mag;
        if (!same_next && (a_mag < b_mag))
        begin
            sign_next = sb_eff;
            x_next    = b_mag;
            y_next    = a_mag;
        end
    end

    // stage 2: add or subtract magnitudes, carry out is overflow
    always_comb
    begin
        if (same_reg)
            wide = {1'b0, x_reg} + {1'b0, y_reg};
        else
            wide = {1'b0, x_reg} - {1'b0, y_reg};
        sum_next.sign = sign_reg;
        sum_next.mag  = wide[MAG_W-1:0];
        sum_next.ovf  = same_reg & wide[MAG_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            same_reg   <= same_next;
            sign_reg   <= sign_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            dly_reg[0] <= sum_next;
            for (int i = 1; i < DEPTH - 1; i++)
                dly_reg[i] <= dly_reg[i-1];
        end
    end

    assign res = dly_reg[DEPTH-2];

endmodule
`default_nettype wire

>>> hdl/wfa_mul.sv
// Pipelined 128x128 magnitude multiplier with shift by the fraction width
// and round half up. Five register stages. Depends on wfa_pkg.
`default_nettype none
module wfa_mul
    import wfa_pkg::*;
(
    input  wire logic clk,
    input  wire logic en,
    input  wire logic sign,
    input  wire mag_t a_mag,
    input  wire mag_t b_mag,
    output result_t   res
);

    logic [2*WORD_W-1:0] pp_reg [WORDS][WORDS];
    logic [159:0]        row_reg [WORDS];
    logic [191:0]        pair_reg [2];
    logic [2*MAG_W-1:0]  prod_reg;
    result_t             res_reg, res_next;
    logic [DEPTH-2:0]    sign_reg;
    logic [MAG_W:0]      rnd;

    // final stage: take product bits 223..96, round on bit 95
    always_comb
    begin
        rnd = {1'b0, prod_reg[FRAC_W+MAG_W-1:FRAC_W]} + {{MAG_W{1'b0}}, prod_reg[FRAC_W-1]};
        res_next.sign = sign_reg[DEPTH-2];
        res_next.mag  = rnd[MAG_W-1:0];
        res_next.ovf  = rnd[MAG_W] | (|prod_reg[2*MAG_W-1:FRAC_W+MAG_W]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: word partial products
            for (int i = 0; i < WORDS; i++)
                for (int j = 0; j < WORDS; j++)
                    pp_reg[i][j] <= {32'd0, a_mag[i*WORD_W +: WORD_W]}
                                  * {32'd0, b_mag[j*WORD_W +: WORD_W]};
            // stage 2: one row per word of a
            for (int i = 0; i < WORDS; i++)
                row_reg[i] <= {32'd0, pp_reg[i][2], pp_reg[i][0]}
                            + {pp_reg[i][3], pp_reg[i][1], 32'd0};
            // stage 3: pairs of rows
            pair_reg[0] <= {32'd0, row_reg[0]} + {row_reg[1], 32'd0};
            pair_reg[1] <= {32'd0, row_reg[2]} + {row_reg[3], 32'd0};
            // stage 4: full product
            prod_reg <= {64'd0, pair_reg[0]} + {pair_reg[1], 64'd0};
            // stage 5: round and flag
            res_reg  <= res_next;
            sign_reg <= {sign_reg[DEPTH-3:0], sign};
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

>>> hdl/wide_fixed_point_alu.sv
// Top level of the wide fixed-point ALU: stream ports, stage valid bits,
// result select. Depends on wfa_pkg, wfa_addsub and wfa_mul.
//
//  channel | dir | fields
//  s_*     | in  | req_type, a_sign, a_hi, a_lo, b_sign, b_hi, b_lo
//  m_*     | out | res_sign, res_hi, res_lo, overflow
//
// One item per cycle sustained unless a result waits on m_tready.
// Latency is set by the multiplier: partial products, rows, pairs, sum, round.
// The whole pipeline advances when the last stage is empty or taken.
// Reset clears the stage valid bits only.
`default_nettype none
module wide_fixed_point_alu
    import wfa_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output      logic            s_tready,
    // req_type[1:0], a_sign[2], a_hi[66:3], a_lo[130:67], b_sign[131],
    // b_hi[195:132], b_lo[259:196], zero pad
    input  wire logic [IN_W-1:0] s_tdata,
    output      logic            m_tvalid,
    input  wire logic            m_tready,
    // res_sign[0], res_hi[64:1], res_lo[128:65], overflow[129], zero pad
    output      logic [OUT_W-1:0] m_tdata
);

    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [DEPTH-1:0] mul_reg, mul_next;
    logic             en;
    logic [1:0]       op;
    mag_t             a_mag, b_mag;
    result_t          as_res, mul_res, res;

    assign op    = s_tdata[1:0];
    assign a_mag = {s_tdata[66:3], s_tdata[130:67]};
    assign b_mag = {s_tdata[195:132], s_tdata[259:196]};

    // global advance
    assign en       = !valid_reg[DEPTH-1] || m_tready;
    assign s_tready = en;

    always_comb
    begin
        valid_next = {valid_reg[DEPTH-2:0], s_tvalid};
        mul_next   = {mul_reg[DEPTH-2:0], (op == OP_MUL)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            mul_reg <= mul_next;
    end

    wfa_addsub u_addsub (
        .clk    (clk),
        .en     (en),
        .op     (op),
        .a_sign (s_tdata[2]),
        .a_mag  (a_mag),
        .b_sign (s_tdata[131]),
        .b_mag  (b_mag),
        .res    (as_res)
    );

    wfa_mul u_mul (
        .clk   (clk),
        .en    (en),
        .sign  (s_tdata[2] ^ s_tdata[131]),
        .a_mag (a_mag),
        .b_mag (b_mag),
        .res   (mul_res)
    );

    // output select
    assign res      = mul_reg[DEPTH-1] ? mul_res : as_res;
    assign m_tvalid = valid_reg[DEPTH-1];
    assign m_tdata  = {6'd0, res.ovf, res.mag[63:0], res.mag[127:64], res.sign};

endmodule
`default_nettype wire

>>> hdl/wfa_checker.sv
// Port-level checks for wide_fixed_point_alu, bound to the top level.
// Depends on wfa_pkg.
`default_nettype none
module wfa_checker
    import wfa_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // input side stalls exactly when the result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not follow output stall");

    // nothing comes out right after reset
    assert property (@(posedge clk) $rose(rst_n) |-> !m_tvalid)
        else $error("result valid out of reset");

    // pad bits are zero on every valid result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_W-1:130] == '0)
        else $error("pad bits set");

endmodule

bind wide_fixed_point_alu wfa_checker u_wfa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

>>> test/tb_wide_fixed_point_alu.sv
// Self-checking testbench for wide_fixed_point_alu: drives random and edge-case
// add/sub/mul transfers and compares every result against a local predictor.
// Depends on wfa_pkg and the wide_fixed_point_alu RTL.
`timescale 1ns / 100ps
`default_nettype none

module tb_wide_fixed_point_alu;
    import wfa_pkg::*;

    typedef struct packed {
        logic        res_sign;
        logic [63:0] res_hi;
        logic [63:0] res_lo;
        logic        overflow;
    } alu_result_t;

    // Arithmetic predictor on 128-bit sign-magnitude numbers
    function automatic alu_result_t compute_alu(logic [1:0] op, logic sa, logic [127:0] ma,
                                                logic sb, logic [127:0] mb);
        alu_result_t r;
        logic [255:0] prod;
        logic [128:0] wide;
        logic [127:0] mag;
        logic         sgn;
        logic         ovf;
        ovf = 1'b0;
        if (op == OP_MUL) begin
            prod = {128'd0, ma} * {128'd0, mb};
            if (prod[255:224] != 32'd0)
                ovf = 1'b1;
            wide = {1'b0, prod[223:96]} + {128'd0, prod[95]};
            if (wide[128])
                ovf = 1'b1;
            mag = wide[127:0];
            sgn = sa ^ sb;
        end
        else begin
            if (op == OP_SUB)
                sb = ~sb;
            if (sa == sb) begin
                wide = {1'b0, ma} + {1'b0, mb};
                mag  = wide[127:0];
                ovf  = wide[128];
                sgn  = sa;
            end
            else if (ma < mb) begin
                mag = mb - ma;
                sgn = sb;
            end
            else begin
                mag = ma - mb;
                sgn = sa;
            end
        end
        r.res_sign = sgn;
        r.res_hi   = mag[127:64];
        r.res_lo   = mag[63:0];
        r.overflow = ovf;
        return r;
    endfunction

    class alu_scoreboard;
        alu_result_t pending_results[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        function void note_request(logic [IN_W-1:0] d);
            alu_result_t exp_res;
            exp_res = compute_alu(d[1:0], d[2], {d[66:3], d[130:67]},
                                  d[131], {d[195:132], d[259:196]});
            pending_results = {pending_results, exp_res};
        endfunction

        function void check_result(logic [OUT_W-1:0] d);
            alu_result_t want;
            alu_result_t got;
            got = {d[0], d[64:1], d[128:65], d[129]};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
            end
            else begin
                want = pending_results.pop_front();
                if (got !== want || d[OUT_W-1:130] !== '0) begin
                    $display("%0t: result mismatch: expected sign %b hi %h lo %h ovf %b",
                             $realtime, want.res_sign, want.res_hi, want.res_lo,
                             want.overflow);
                    $display("%0t:                  actual   sign %b hi %h lo %h ovf %b",
                             $realtime, got.res_sign, got.res_hi, got.res_lo,
                             got.overflow);
                    errors++;
                end
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    alu_scoreboard sb;
    bit            quiet_phase;
    bit            hold_off;
    bit            stim_done;

    wide_fixed_point_alu dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [127:0] rand_mag();
        logic [127:0] m;
        m = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 9))
            0: m = '0;
            1: m = '1;
            2: m[127:96] = '0;                       // zero integer part
            3: m[127:112] = '0;                      // products stay in range
            4: m = {$urandom_range(0, 3), 96'd0} | {96'd0, m[31:0]};
            5: m = 128'd1 << $urandom_range(0, 127);
            default: ;
        endcase
        return m;
    endfunction

    // One transfer on the input stream, with random idle gaps
    task automatic send_op(logic [1:0] op, logic sa, logic [127:0] ma,
                           logic sb_, logic [127:0] mb);
        while (!quiet_phase && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, mb[63:0], mb[127:64], sb_, ma[63:0], ma[127:64], sa, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(s_tdata);
        @(negedge clk);
    endtask

    task automatic send_random();
        logic [1:0]   op;
        logic [127:0] ma;
        logic [127:0] mb;
        op = 2'($urandom_range(0, 3));
        ma = rand_mag();
        mb = ($urandom_range(0, 9) == 0) ? ma : rand_mag();
        send_op(op, 1'($urandom_range(0, 1)), ma, 1'($urandom_range(0, 1)), mb);
    endtask

    // Output side: random stalls plus one long hold-off
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                m_tready <= 1'b0;
            else
                m_tready <= quiet_phase || ($urandom_range(0, 99) >= 7);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    initial
    begin
        int i;
        int wait_cycles;
        logic [127:0] one;
        logic [127:0] half;
        sb          = new();
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        quiet_phase = 1'b0;
        hold_off    = 1'b0;
        stim_done   = 1'b0;
        one         = 128'd1 << 96;
        half        = 128'd1 << 95;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, every operation, special cases
        send_op(OP_ADD, 1'b0, '1, 1'b0, '1);             // add wraps
        send_op(OP_ADD, 1'b0, '1, 1'b0, 128'd1);
        send_op(OP_ADD, 1'b1, '0, 1'b1, '0);
        send_op(OP_ADD, 1'b0, one, 1'b1, one);           // equal magnitudes
        send_op(OP_ADD, 1'b1, one, 1'b0, one);
        send_op(OP_ADD, 1'b0, one, 1'b1, '1);            // larger second operand
        send_op(OP_SUB, 1'b0, one, 1'b0, one);           // flip then equal
        send_op(OP_SUB, 1'b1, '1, 1'b1, '0);
        send_op(OP_SUB, 1'b0, '0, 1'b1, '1);             // subtract becomes add
        send_op(OP_SUB, 1'b1, 128'd5, 1'b0, 128'd7);
        send_op(OP_MUL, 1'b0, one, 1'b0, one);
        send_op(OP_MUL, 1'b1, '0, 1'b0, '1);             // zero product keeps XOR sign
        send_op(OP_MUL, 1'b1, '1, 1'b1, '1);             // wide overflow
        send_op(OP_MUL, 1'b0, half, 1'b0, 128'd1);       // rounds up on discarded bit
        send_op(OP_MUL, 1'b0, half - 128'd1, 1'b0, 128'd1);  // rounds down
        send_op(OP_MUL, 1'b0, {32'hFFFF_FFFF, 96'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF}, 1'b1, one);
        send_op(OP_MUL, 1'b0, 128'd1 << 112, 1'b0, 128'd1 << 112);  // just carries past integer
        send_op(2'd3, 1'b0, '1, 1'b0, 128'd1);           // unused code acts as add
        send_op(2'd3, 1'b1, one, 1'b0, 128'd3);

        // Random with gaps
        for (i = 0; i < 400; i++)
            send_random();

        // Long receiver hold-off while the sender keeps offering
        hold_off = 1'b1;
        fork
            begin
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
            for (i = 0; i < 80; i++)
                send_random();
        join

        // Full-rate stretch with no idling
        quiet_phase = 1'b1;
        for (i = 0; i < 200; i++)
            send_random();
        quiet_phase = 1'b0;

        for (i = 0; i < 420; i++)
            send_random();
        s_tvalid <= 1'b0;

        // Drain
        wait_cycles = 0;
        while (sb.pending_results.size() != 0 && wait_cycles < 10000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hdl/wfa_pkg.sv
hdl/wfa_addsub.sv
hdl/wfa_mul.sv
hdl/wide_fixed_point_alu.sv
hdl/wfa_checker.sv
test/tb_wide_fixed_point_alu.sv
